@@ hw/rtl/dsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DiSEqC switch command sequencer package
// Field widths, action and type codes, and fixed message bytes.
// ----------------------------------------------------------------------------
package dsc_pkg;

   localparam int SAT_W   = 6;
   localparam int FREQ_W  = 27;
   localparam int LEN_W   = 3;
   localparam int MSG_W   = 48;
   localparam int CSR_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int BCD_DIGITS = 9;
   localparam int BCD_W   = 4 * BCD_DIGITS;

   // action codes
   localparam logic [1:0] ACT_TONE  = 2'd0;
   localparam logic [1:0] ACT_VOLT  = 2'd1;
   localparam logic [1:0] ACT_MSG   = 2'd2;
   localparam logic [1:0] ACT_BURST = 2'd3;

   // protocol type codes
   localparam logic [2:0] TYPE_NONE  = 3'd0;
   localparam logic [2:0] TYPE_MINI  = 3'd1;
   localparam logic [2:0] TYPE_SMATV = 3'd2;
   localparam logic [2:0] TYPE_DQ10  = 3'd3;
   localparam logic [2:0] TYPE_DQ11  = 3'd4;
   localparam logic [2:0] TYPE_DQ12  = 3'd5;

   // uncommitted modes
   localparam logic [1:0] UNC_NONE  = 2'd0;
   localparam logic [1:0] UNC_GROUP = 2'd1;
   localparam logic [1:0] UNC_SAT   = 2'd2;
   localparam logic [1:0] UNC_BAD   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TYPE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_UNC    = 2'd2;

   // message bytes
   localparam logic [7:0] FRM_FIRST  = 8'hE0;
   localparam logic [7:0] FRM_REPEAT = 8'hE1;
   localparam logic [7:0] ADR_SWITCH = 8'h10;
   localparam logic [7:0] ADR_SMATV  = 8'h71;
   localparam logic [7:0] CMD_COMMIT = 8'h38;
   localparam logic [7:0] CMD_UNCOMM = 8'h39;
   localparam logic [7:0] CMD_FREQ   = 8'h58;
   localparam logic [7:0] PORT_BASE  = 8'hF0;
   localparam logic [7:0] NO_SAT     = 8'hFF;

   localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
   localparam logic [LEN_W-1:0] LEN_SHORT = 3'd4;
   localparam logic [LEN_W-1:0] LEN_LONG  = 3'd6;

endpackage

@@ hw/rtl/diseqc_switch_command_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DiSEqC switch command sequencer
// Turns one tune request into the ordered list of LNB actions.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  sat, polarity, band, IF kHz
//  rsp      out        rsp_valid / rsp_stall  action, level, length, bytes, last
//  csr      in         csr_write_enable       index, write data
//
//  One action leaves per cycle while the result side does not stall.
//  SMATV requests first run a shift-add-3 BCD conversion of the IF
//  frequency; a request yields 2 to 34 actions. The request side stalls
//  until the last action is loaded. Reset is synchronous and clears the
//  sequencer, the registers and the remembered satellite (no satellite yet).
// ----------------------------------------------------------------------------
module diseqc_switch_command_sequencer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dsc_pkg::SAT_W-1:0]        req_sat_number,
   input  logic                             req_polarity_bit,
   input  logic                             req_high_band,
   input  logic [dsc_pkg::FREQ_W-1:0]       req_if_frequency,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_action,
   output logic                             rsp_level,
   output logic [dsc_pkg::LEN_W-1:0]        rsp_message_length,
   output logic [dsc_pkg::MSG_W-1:0]        rsp_message_bytes,
   output logic                             rsp_last,
   input  logic                             csr_write_enable,
   input  logic [dsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dsc_pkg::CSR_W-1:0]        csr_write_data
);
   import dsc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_BCD, ST_TONE, ST_VOLT, ST_UNC_FIRST, ST_UNC_REP,
      ST_COMMIT, ST_REP_UNC, ST_REP_COM, ST_SMATV, ST_BURST
   } state_type;

   state_type            state_ff, state_in, after_unc, after_com;
   logic [2:0]           type_ff;
   logic [3:0]           rep_ff;
   logic [1:0]           mode_ff;
   logic [7:0]           prev_sat_ff;

   logic                 hb_ff, pol_ff, sat0_ff, send_ff, first_ff, first_in;
   logic [7:0]           xx_ff, cc_ff;
   logic [3:0]           cnt_ff, cnt_in;
   logic [FREQ_W-1:0]    bin_ff;
   logic [BCD_W-1:0]     bcd_ff, bcd_adj;
   logic [4:0]           bit_cnt_ff;

   logic                 rsp_valid_ff, rsp_level_ff, rsp_last_ff;
   logic [1:0]           rsp_action_ff;
   logic [LEN_W-1:0]     rsp_len_ff;
   logic [MSG_W-1:0]     rsp_bytes_ff;

   logic                 out_free, accept, emit;
   logic [1:0]           act_in;
   logic                 lvl_in;
   logic [LEN_W-1:0]     len_in;
   logic [MSG_W-1:0]     bytes_in;
   logic                 unc_on, unc_send, unc_update;
   logic [7:0]           cc_in, xx_in;

   assign req_stall          = (state_ff != ST_IDLE);
   assign accept             = req_valid && !req_stall;
   assign out_free           = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = rsp_action_ff;
   assign rsp_level          = rsp_level_ff;
   assign rsp_message_length = rsp_len_ff;
   assign rsp_message_bytes  = rsp_bytes_ff;
   assign rsp_last           = rsp_last_ff;

   // request decode
   always_comb begin
      unc_update = (type_ff == TYPE_DQ11) && (mode_ff != UNC_NONE);
      xx_in = PORT_BASE | {4'd0, req_sat_number[1:0], !req_polarity_bit, req_high_band};
      if (mode_ff == UNC_GROUP) begin
         unc_on = (prev_sat_ff[7:2] != {2'd0, req_sat_number[5:2]});
         cc_in  = PORT_BASE + {4'd0, req_sat_number[5:2]};
      end else begin
         unc_on = (prev_sat_ff != {2'd0, req_sat_number});
         cc_in  = PORT_BASE + {2'd0, req_sat_number};
      end
      unc_send = unc_update && unc_on;
   end

   // shift-add-3 digit correction
   always_comb begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         else bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
      end
   end

   // step sequencing
   always_comb begin
      if (type_ff >= TYPE_SMATV) after_unc = ST_COMMIT;
      else if (type_ff == TYPE_MINI) after_unc = ST_BURST;
      else after_unc = ST_IDLE;

      if (type_ff >= TYPE_DQ11 && rep_ff != 4'd0)
         after_com = (mode_ff == UNC_NONE) ? ST_REP_UNC : ST_REP_COM;
      else if (type_ff == TYPE_SMATV) after_com = ST_SMATV;
      else if (type_ff == TYPE_DQ10) after_com = ST_BURST;
      else after_com = ST_IDLE;

      state_in = state_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      emit     = 1'b0;
      act_in   = ACT_MSG;
      lvl_in   = 1'b0;
      len_in   = LEN_SHORT;
      bytes_in = '0;
      unique case (state_ff)
         ST_IDLE, ST_BCD: begin
            len_in = LEN_NONE;
         end
         ST_TONE: begin
            emit = 1'b1; act_in = ACT_TONE; lvl_in = hb_ff; len_in = LEN_NONE;
            state_in = ST_VOLT;
         end
         ST_VOLT: begin
            emit = 1'b1; act_in = ACT_VOLT; lvl_in = pol_ff; len_in = LEN_NONE;
            state_in = send_ff ? ST_UNC_FIRST : after_unc;
         end
         ST_UNC_FIRST: begin
            emit = 1'b1;
            bytes_in = {FRM_FIRST, ADR_SWITCH, CMD_UNCOMM, cc_ff, 16'd0};
            cnt_in = rep_ff;
            state_in = (rep_ff != 4'd0) ? ST_UNC_REP : after_unc;
         end
         ST_UNC_REP: begin
            emit = 1'b1;
            bytes_in = {FRM_REPEAT, ADR_SWITCH, CMD_UNCOMM, cc_ff, 16'd0};
            cnt_in = cnt_ff - 4'd1;
            state_in = (cnt_ff > 4'd1) ? ST_UNC_REP : after_unc;
         end
         ST_COMMIT: begin
            emit = 1'b1;
            bytes_in = {FRM_FIRST, ADR_SWITCH, CMD_COMMIT, xx_ff, 16'd0};
            cnt_in = rep_ff;
            first_in = 1'b1;
            state_in = after_com;
         end
         ST_REP_UNC: begin
            emit = 1'b1;
            bytes_in = {first_ff ? FRM_FIRST : FRM_REPEAT, ADR_SWITCH, CMD_UNCOMM,
                        xx_ff, 16'd0};
            first_in = 1'b0;
            state_in = ST_REP_COM;
         end
         ST_REP_COM: begin
            emit = 1'b1;
            bytes_in = {FRM_REPEAT, ADR_SWITCH, CMD_COMMIT, xx_ff, 16'd0};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff > 4'd1)
               state_in = (mode_ff == UNC_NONE) ? ST_REP_UNC : ST_REP_COM;
            else
               state_in = ST_IDLE;
         end
         ST_SMATV: begin
            emit = 1'b1; len_in = LEN_LONG;
            bytes_in = {FRM_FIRST, ADR_SMATV, CMD_FREQ, bcd_ff[31:8]};
            state_in = ST_IDLE;
         end
         ST_BURST: begin
            emit = 1'b1; act_in = ACT_BURST; lvl_in = sat0_ff; len_in = LEN_NONE;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         type_ff      <= TYPE_NONE;
         rep_ff       <= 4'd0;
         mode_ff      <= UNC_NONE;
         prev_sat_ff  <= NO_SAT;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_TYPE:   if (csr_write_data[2:0] <= TYPE_DQ12) type_ff <= csr_write_data[2:0];
               REG_REPEAT: rep_ff <= csr_write_data;
               REG_UNC:    mode_ff <= (csr_write_data[1:0] == UNC_BAD) ? UNC_NONE
                                                                      : csr_write_data[1:0];
               default: ;
            endcase
         end

         if (out_free) rsp_valid_ff <= emit;

         if (accept) begin
            hb_ff   <= req_high_band;
            pol_ff  <= req_polarity_bit;
            sat0_ff <= req_sat_number[0];
            xx_ff   <= xx_in;
            cc_ff   <= cc_in;
            send_ff <= unc_send;
            if (unc_update) prev_sat_ff <= {2'd0, req_sat_number};
            bin_ff     <= req_if_frequency;
            bcd_ff     <= '0;
            bit_cnt_ff <= 5'(FREQ_W);
            state_ff   <= (type_ff == TYPE_SMATV) ? ST_BCD : ST_TONE;
         end else if (state_ff == ST_BCD) begin
            bcd_ff     <= {bcd_adj[BCD_W-2:0], bin_ff[FREQ_W-1]};
            bin_ff     <= {bin_ff[FREQ_W-2:0], 1'b0};
            bit_cnt_ff <= bit_cnt_ff - 5'd1;
            if (bit_cnt_ff == 5'd1) state_ff <= ST_TONE;
         end else if (emit && out_free) begin
            state_ff      <= state_in;
            cnt_ff        <= cnt_in;
            first_ff      <= first_in;
            rsp_action_ff <= act_in;
            rsp_level_ff  <= lvl_in;
            rsp_len_ff    <= len_in;
            rsp_bytes_ff  <= bytes_in;
            rsp_last_ff   <= (state_in == ST_IDLE);
         end
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request taken while sequence still running");

   a_plain_action_no_msg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action != ACT_MSG) |->
         (rsp_message_length == LEN_NONE && rsp_message_bytes == '0))
      else $error("non-message action carries message bytes");

   a_msg_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_MSG) |->
         (rsp_message_length == LEN_SHORT || rsp_message_length == LEN_LONG))
      else $error("message beat with bad length");

   a_type_legal: assert property (@(posedge clock) disable iff (reset)
      type_ff <= TYPE_DQ12)
      else $error("undefined protocol type stored");

   a_idle_only_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_BCD && emit && out_free
         && state_in == ST_IDLE) |=> (rsp_valid && rsp_last))
      else $error("sequence ended without a last beat");

endmodule

@@ sim/diseqc_switch_command_sequencer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DiSEqC switch command sequencer testbench
// Sends tune requests under a range of register settings. An in-bench
// predictor works out the expected LNB actions for each accepted request,
// and each result beat is checked against them, field by field. The request
// side idles and the result side stalls at random.
// ----------------------------------------------------------------------------
module diseqc_switch_command_sequencer_core_tb;
   import dsc_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 500;

   typedef struct packed {
      logic [1:0]       action;
      logic             level;
      logic [LEN_W-1:0] len;
      logic [MSG_W-1:0] bytes;
      logic             last;
   } lnb_action_type;

   typedef struct packed {
      logic [SAT_W-1:0]  sat;
      logic              pol;
      logic              band;
      logic [FREQ_W-1:0] freq;
      logic              hold_for_drain;
   } tune_req_type;

   typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PULSE} flow_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [SAT_W-1:0]     req_sat_number = '0;
   logic                 req_polarity_bit = 1'b0;
   logic                 req_high_band = 1'b0;
   logic [FREQ_W-1:0]    req_if_frequency = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_action;
   logic                 rsp_level;
   logic [LEN_W-1:0]     rsp_message_length;
   logic [MSG_W-1:0]     rsp_message_bytes;
   logic                 rsp_last;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_TYPE;
   logic [CSR_W-1:0]     csr_write_data = '0;

   // predictor copy of the registers and the remembered satellite
   logic [2:0] cfg_type = TYPE_NONE;
   logic [3:0] cfg_repeat = '0;
   logic [1:0] cfg_unc = UNC_NONE;
   logic [7:0] last_sat = NO_SAT;

   tune_req_type   pending_tunes [$];
   lnb_action_type actions_owed [$];
   tune_req_type   cur_tune;
   int             tunes_queued = 0;
   int             tunes_accepted = 0;
   int             results_owed = 0;
   int             mismatches = 0;
   int             quiet_cycles = 0;

   diseqc_switch_command_sequencer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sat_number     (req_sat_number),
      .req_polarity_bit   (req_polarity_bit),
      .req_high_band      (req_high_band),
      .req_if_frequency   (req_if_frequency),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_action         (rsp_action),
      .rsp_level          (rsp_level),
      .rsp_message_length (rsp_message_length),
      .rsp_message_bytes  (rsp_message_bytes),
      .rsp_last           (rsp_last),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic logic [MSG_W-1:0] short_msg(logic [7:0] b0, logic [7:0] b1,
                                                  logic [7:0] b2, logic [7:0] b3);
      return {b0, b1, b2, b3, 16'h0000};
   endfunction

   function automatic lnb_action_type mk_action(logic [1:0] act, logic lvl,
                                                logic [LEN_W-1:0] len,
                                                logic [MSG_W-1:0] bytes);
      return {act, lvl, len, bytes, 1'b0};
   endfunction

   // expected LNB actions for one accepted tune request
   function automatic void forecast_actions(logic [SAT_W-1:0] sat, logic pol, logic band,
                                            logic [FREQ_W-1:0] freq);
      lnb_action_type acts [0:47];
      int          n;
      int          i;
      int          div;
      logic [7:0]  sw;
      logic [7:0]  port;
      logic [7:0]  first;
      logic [23:0] bcd;
      logic        send;
      n = 0;
      sw = PORT_BASE | {4'h0, sat[1:0], ~pol, band};
      acts[n] = mk_action(ACT_TONE, band, LEN_NONE, '0);
      n = n + 1;
      acts[n] = mk_action(ACT_VOLT, pol, LEN_NONE, '0);
      n = n + 1;
      if (cfg_type == TYPE_DQ11 && cfg_unc != UNC_NONE) begin
         send = 1'b0;
         port = '0;
         if (cfg_unc == UNC_GROUP && (last_sat >> 2) != {4'h0, sat[5:2]}) begin
            send = 1'b1;
            port = PORT_BASE + {4'h0, sat[5:2]};
         end else if (cfg_unc == UNC_SAT && last_sat != {2'b00, sat}) begin
            send = 1'b1;
            port = PORT_BASE + {2'b00, sat};
         end
         if (send) begin
            acts[n] = mk_action(ACT_MSG, 1'b0, LEN_SHORT,
                                short_msg(FRM_FIRST, ADR_SWITCH, CMD_UNCOMM, port));
            n = n + 1;
            for (i = 0; i < cfg_repeat; i++) begin
               acts[n] = mk_action(ACT_MSG, 1'b0, LEN_SHORT,
                                   short_msg(FRM_REPEAT, ADR_SWITCH, CMD_UNCOMM, port));
               n = n + 1;
            end
         end
         last_sat = {2'b00, sat};
      end
      if (cfg_type >= TYPE_SMATV) begin
         acts[n] = mk_action(ACT_MSG, 1'b0, LEN_SHORT,
                             short_msg(FRM_FIRST, ADR_SWITCH, CMD_COMMIT, sw));
         n = n + 1;
      end
      if (cfg_type >= TYPE_DQ11) begin
         first = FRM_FIRST;
         for (i = 0; i < cfg_repeat; i++) begin
            if (cfg_unc == UNC_NONE) begin
               acts[n] = mk_action(ACT_MSG, 1'b0, LEN_SHORT,
                                   short_msg(first, ADR_SWITCH, CMD_UNCOMM, sw));
               n = n + 1;
            end
            first = FRM_REPEAT;
            acts[n] = mk_action(ACT_MSG, 1'b0, LEN_SHORT,
                                short_msg(FRM_REPEAT, ADR_SWITCH, CMD_COMMIT, sw));
            n = n + 1;
         end
      end
      if (cfg_type == TYPE_SMATV) begin
         bcd = '0;
         div = 10000000;
         for (i = 0; i < 6; i++) begin
            bcd = {bcd[19:0], 4'((int'(freq) / div) % 10)};
            div = div / 10;
         end
         acts[n] = mk_action(ACT_MSG, 1'b0, LEN_LONG, {FRM_FIRST, ADR_SMATV, CMD_FREQ, bcd});
         n = n + 1;
      end
      if (cfg_type == TYPE_MINI || cfg_type == TYPE_DQ10) begin
         acts[n] = mk_action(ACT_BURST, sat[0], LEN_NONE, '0);
         n = n + 1;
      end
      acts[n-1].last = 1'b1;
      for (i = 0; i < n; i++) actions_owed.push_back(acts[i]);
   endfunction

   task automatic report_mismatch(string what);
      if (mismatches < 100) $display("ERROR at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [MSG_W-1:0] got_v, logic [MSG_W-1:0] want_v);
      if (got_v !== want_v)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got_v, want_v));
   endtask

   task automatic queue_tune(logic [SAT_W-1:0] sat, logic pol, logic band,
                             logic [FREQ_W-1:0] freq, logic hold);
      pending_tunes.push_back({sat, pol, band, freq, hold});
      tunes_queued++;
   endtask

   task automatic wait_settled();
      while (!(tunes_accepted == tunes_queued && results_owed == 0)) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // write all three registers on back-to-back edges, block idle
   task automatic set_config(logic [3:0] ty, logic [3:0] rep, logic [3:0] unc);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_TYPE;
      csr_write_data   <= ty;
      if (ty[2:0] <= TYPE_DQ12) cfg_type = ty[2:0];
      @(posedge clock);
      csr_index        <= REG_REPEAT;
      csr_write_data   <= rep;
      cfg_repeat = rep;
      @(posedge clock);
      csr_index        <= REG_UNC;
      csr_write_data   <= unc;
      cfg_unc = (unc[1:0] == UNC_BAD) ? UNC_NONE : unc[1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // sender: bursts of beats with random gaps
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin : feed
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         offer = req_valid && req_stall;
         if (req_valid && !req_stall) begin
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
         end
         if (!offer && gap_left > 0) begin
            gap_left = gap_left - 1;
         end else if (!offer && pending_tunes.size() > 0 &&
                      (!pending_tunes[0].hold_for_drain ||
                       (!req_valid && results_owed == 0))) begin
            cur_tune = pending_tunes.pop_front();
            req_sat_number   <= cur_tune.sat;
            req_polarity_bit <= cur_tune.pol;
            req_high_band    <= cur_tune.band;
            req_if_frequency <= cur_tune.freq;
            offer = 1'b1;
         end
         req_valid <= offer;
      end
   end

   // receiver: stall styles that change now and then, plus long hold-offs
   flow_type flow_style = FLOW_FREE;
   int       flow_left = 0;
   int       flow_tick = 0;
   int       hold_left = 0;
   int       beats_taken = 0;
   int       next_hold_at = 150;

   always @(posedge clock) begin : sink
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         flow_tick++;
         if (rsp_valid && !rsp_stall) beats_taken++;
         if (hold_left == 0 && beats_taken >= next_hold_at) begin
            hold_left = HOLD_CYCLES;
            next_hold_at = next_hold_at + 2000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (flow_left == 0) begin
               flow_style = flow_type'($urandom_range(0, 3));
               flow_left = $urandom_range(20, 200);
            end
            flow_left--;
            case (flow_style)
               FLOW_FREE:  rsp_stall <= 1'b0;
               FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:    rsp_stall <= (flow_tick % 7) < 3;
            endcase
         end
      end
   end

   // predict on each accepted request, check each accepted result
   always @(posedge clock) begin : score
      lnb_action_type got;
      lnb_action_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            forecast_actions(req_sat_number, req_polarity_bit, req_high_band, req_if_frequency);
            tunes_accepted <= tunes_accepted + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_action, rsp_level, rsp_message_length, rsp_message_bytes, rsp_last};
            if (actions_owed.size() == 0) begin
               report_mismatch($sformatf("action %0d arrived with nothing expected",
                                         got.action));
            end else begin
               want = actions_owed.pop_front();
               check_field("action", MSG_W'(got.action), MSG_W'(want.action));
               check_field("level", MSG_W'(got.level), MSG_W'(want.level));
               check_field("message_length", MSG_W'(got.len), MSG_W'(want.len));
               check_field("message_bytes", got.bytes, want.bytes);
               check_field("last", MSG_W'(got.last), MSG_W'(want.last));
            end
         end
         results_owed <= actions_owed.size();
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("diseqc_switch_command_sequencer_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int          random_tunes;
      int          count;
      int          pick;
      logic [3:0]  ty;
      logic [5:0]  sat;
      logic [26:0] freq;
      random_tunes = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // registers at their reset values
      queue_tune(6'd0, 1'b0, 1'b0, 27'd0, 1'b0);
      queue_tune(6'd63, 1'b1, 1'b1, 27'h7FFFFFF, 1'b0);
      wait_settled();
      set_config(4'(TYPE_MINI), 4'd0, 4'(UNC_NONE));
      queue_tune(6'd2, 1'b1, 1'b0, 27'd1000, 1'b0);
      queue_tune(6'd1, 1'b0, 1'b1, 27'd5, 1'b0);
      wait_settled();
      set_config(4'(TYPE_SMATV), 4'd3, 4'(UNC_GROUP));
      queue_tune(6'd5, 1'b0, 1'b1, 27'd0, 1'b0);
      queue_tune(6'd40, 1'b1, 1'b0, 27'd99999999, 1'b0);
      queue_tune(6'd63, 1'b0, 1'b0, 27'h7FFFFFF, 1'b0);
      queue_tune(6'd17, 1'b1, 1'b1, 27'd12345678, 1'b0);
      wait_settled();
      set_config(4'(TYPE_DQ10), 4'd15, 4'(UNC_SAT));
      queue_tune(6'd3, 1'b1, 1'b1, 27'd0, 1'b0);
      queue_tune(6'd60, 1'b0, 1'b0, 27'd0, 1'b0);
      wait_settled();
      set_config(4'(TYPE_DQ11), 4'd15, 4'(UNC_NONE));
      queue_tune(6'd7, 1'b0, 1'b1, 27'd0, 1'b0);
      queue_tune(6'd62, 1'b1, 1'b0, 27'd0, 1'b0);
      wait_settled();
      // switch group changes only across groups of four
      set_config(4'(TYPE_DQ11), 4'd2, 4'(UNC_GROUP));
      queue_tune(6'd0, 1'b1, 1'b0, 27'd0, 1'b0);
      queue_tune(6'd3, 1'b0, 1'b1, 27'd0, 1'b0);
      queue_tune(6'd4, 1'b1, 1'b1, 27'd0, 1'b0);
      queue_tune(6'd63, 1'b0, 1'b0, 27'd0, 1'b0);
      wait_settled();
      set_config(4'(TYPE_DQ11), 4'd1, 4'(UNC_SAT));
      queue_tune(6'd63, 1'b1, 1'b0, 27'd0, 1'b0);
      queue_tune(6'd63, 1'b0, 1'b1, 27'd0, 1'b0);
      queue_tune(6'd5, 1'b1, 1'b1, 27'd0, 1'b0);
      wait_settled();
      set_config(4'(TYPE_DQ12), 4'd15, 4'(UNC_SAT));
      queue_tune(6'd9, 1'b0, 1'b1, 27'd0, 1'b0);
      wait_settled();
      // undefined type is dropped, undefined mode reads as none
      set_config(4'd6, 4'd0, {2'b00, UNC_BAD});
      queue_tune(6'd10, 1'b1, 1'b0, 27'd0, 1'b0);
      wait_settled();
      set_config(4'hF, 4'd4, 4'hE);
      queue_tune(6'd33, 1'b0, 1'b1, 27'd0, 1'b0);
      wait_settled();

      while (random_tunes < 450) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) ty = 4'(TYPE_DQ11);
         else if (pick < 8) ty = 4'($urandom_range(0, 5));
         else ty = 4'($urandom_range(0, 15));
         set_config(ty, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         count = $urandom_range(16, 28);
         repeat (count) begin
            sat = $urandom_range(0, 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
            freq = $urandom_range(0, 1) ? 27'($urandom_range(0, 99999999))
                                        : 27'($urandom_range(0, 27'h7FFFFFF));
            queue_tune(sat, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), freq,
                       $urandom_range(0, 39) == 0);
         end
         random_tunes = random_tunes + count;
         wait_settled();
      end

      repeat (40) @(posedge clock);
      if (mismatches == 0 && actions_owed.size() == 0) begin
         $display("diseqc_switch_command_sequencer_core test passed");
      end else begin
         $display("diseqc_switch_command_sequencer_core test failed");
      end
      $finish;
   end

endmodule
